// ===== rtl/core/jrlcg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jrlcg_pkg
// Types and constants of the 48-bit linear congruential generator unit.
// ----------------------------------------------------------------------------
package jrlcg_pkg;

  // LCG multiplier and increment, state taken mod 2^48
  localparam logic [34:0] LCG_MULT = 35'h5DEECE66D;
  localparam logic [47:0] LCG_ADD  = 48'hB;

  // Command codes
  localparam logic [2:0] OP_SET_SEED = 3'd0;
  localparam logic [2:0] OP_NEXT     = 3'd1;
  localparam logic [2:0] OP_INT      = 3'd2;
  localparam logic [2:0] OP_LONG     = 3'd3;
  localparam logic [2:0] OP_DOUBLE   = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CHECK,
    S_DONE
  } seq_state_t;

  // Request payload
  typedef struct packed {
    logic [2:0]  op;
    logic [47:0] seed_value;
    logic [5:0]  bit_count;
    logic [30:0] bound;
  } req_t;

  // Response payload
  typedef struct packed {
    logic signed [63:0] result_value;
    logic [47:0]        state_after;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/java_random_lcg_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// java_random_lcg_generator_unit
// 48-bit LCG random source: set seed, next bits, bounded int, long, 53-bit.
// ----------------------------------------------------------------------------
// One request at a time. Each LCG step runs on a shared 16 x 35 bit multiplier
// that accumulates one 16-bit slice of the state per cycle. Set seed, unused
// codes and a zero bound skip the multiplier; next bits draws once, long and
// 53-bit draw twice, and bounded int draws, runs a bit-serial remainder and a
// check on each attempt, with a fresh attempt on each rejected draw. A finished
// response waits in an output register while the next request is taken.
// ----------------------------------------------------------------------------
module java_random_lcg_generator_unit
  import jrlcg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req_data,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp_data
);

  seq_state_t  state, state_next;
  logic [47:0] gen_state;
  logic [47:0] acc;
  logic [1:0]  mul_idx;
  logic        draw_second;
  logic [2:0]  op_r;
  logic [5:0]  nb_r;
  logic        nb_zero_r;
  logic [30:0] bound_r;
  logic [31:0] hi_r;
  logic [63:0] result_r;
  logic [30:0] bits_r;
  logic [30:0] dshift;
  logic [30:0] rem;
  logic [4:0]  div_cnt;

  logic        accept;
  logic        rsp_free;
  logic [15:0] mul_chunk;
  logic [47:0] mul_prod;
  logic [47:0] mul_term;
  logic [47:0] acc_sum;
  logic        step_last;
  logic [31:0] nb_val;
  logic [31:0] trial;
  logic        trial_ge;
  logic [30:0] rem_next;
  logic [31:0] chk_sum;
  logic        reject;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Multiply one 16-bit slice of the state and accumulate it at its offset
  always_comb begin
    unique case (mul_idx)
      2'd0:    mul_chunk = gen_state[15:0];
      2'd1:    mul_chunk = gen_state[31:16];
      default: mul_chunk = gen_state[47:32];
    endcase
    mul_prod = 48'(mul_chunk) * 48'(LCG_MULT);
    unique case (mul_idx)
      2'd0:    mul_term = mul_prod;
      2'd1:    mul_term = {mul_prod[31:0], 16'b0};
      default: mul_term = {mul_prod[15:0], 32'b0};
    endcase
    acc_sum   = acc + mul_term;
    step_last = (mul_idx == 2'd2);
    nb_val    = acc_sum[47:16] >> (6'd32 - nb_r);
  end

  // Restoring remainder step and rejection check
  always_comb begin
    trial    = {rem, dshift[30]};
    trial_ge = (trial >= {1'b0, bound_r});
    rem_next = trial_ge ? 31'(trial - {1'b0, bound_r}) : trial[30:0];
    chk_sum  = {1'b0, bits_r} - {1'b0, rem} + {1'b0, bound_r} - 32'd1;
    reject   = chk_sum[31];
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          priority case (req_data.op)
            OP_NEXT, OP_LONG, OP_DOUBLE: state_next = S_MUL;
            OP_INT: state_next = (req_data.bound == 31'd0) ? S_DONE : S_MUL;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_MUL: begin
        if (step_last) begin
          if (op_r == OP_INT) begin
            state_next = S_DIV;
          end else if ((op_r == OP_LONG || op_r == OP_DOUBLE) && !draw_second) begin
            state_next = S_MUL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_cnt == 5'd30) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = reject ? S_MUL : S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Generator state: load seed or take the finished step
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= '0;
    end else if (accept && req_data.op == OP_SET_SEED) begin
      gen_state <= req_data.seed_value ^ 48'(LCG_MULT);
    end else if (state == S_MUL && step_last) begin
      gen_state <= acc_sum;
    end
  end

  // Working registers of the multiplier, remainder unit and result
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_r        <= req_data.op;
          nb_zero_r   <= (req_data.bit_count == 6'd0);
          nb_r        <= (req_data.bit_count > 6'd32) ? 6'd32 : req_data.bit_count;
          bound_r     <= req_data.bound;
          draw_second <= 1'b0;
          mul_idx     <= 2'd0;
          acc         <= LCG_ADD;
          result_r    <= '0;
        end
      end
      S_MUL: begin
        if (step_last) begin
          mul_idx <= 2'd0;
          acc     <= LCG_ADD;
          priority case (op_r)
            OP_NEXT: begin
              result_r <= nb_zero_r ? 64'd0 : {{32{nb_val[31]}}, nb_val};
            end
            OP_INT: begin
              bits_r  <= acc_sum[47:17];
              dshift  <= acc_sum[47:17];
              rem     <= '0;
              div_cnt <= '0;
            end
            OP_LONG: begin
              if (!draw_second) begin
                hi_r        <= acc_sum[47:16];
                draw_second <= 1'b1;
              end else begin
                result_r <= {hi_r, 32'b0} + {{32{acc_sum[47]}}, acc_sum[47:16]};
              end
            end
            OP_DOUBLE: begin
              if (!draw_second) begin
                hi_r        <= {6'b0, acc_sum[47:22]};
                draw_second <= 1'b1;
              end else begin
                result_r <= {11'b0, hi_r[25:0], acc_sum[47:21]};
              end
            end
            default: result_r <= '0;
          endcase
        end else begin
          mul_idx <= mul_idx + 2'd1;
          acc     <= acc_sum;
        end
      end
      S_DIV: begin
        rem     <= rem_next;
        dshift  <= {dshift[29:0], 1'b0};
        div_cnt <= div_cnt + 5'd1;
      end
      S_CHECK: begin
        if (!reject) begin
          result_r <= {33'b0, rem};
        end
      end
      default: ;
    endcase
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp_data.result_value <= result_r;
      rsp_data.state_after  <= gen_state;
    end
  end

`ifndef SYNTH
  // An accepted request blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("request taken while busy");

  // The multiplier walks three slices only
  a_mul_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (mul_idx != 2'd3))
    else $error("multiplier slice index out of range");

  // The partial remainder stays below the bound
  a_rem_below_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < bound_r))
    else $error("remainder not below bound");

  // A waiting response reports the current generator state
  a_state_after_match: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && state == S_IDLE) |-> (rsp_data.state_after == gen_state))
    else $error("response state differs from generator state");
`endif

endmodule
`default_nettype wire

// ===== tb/jrlcg_draw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrlcg_draw_checker
// Watches both channels of the LCG unit, predicts each response from its own
// copy of the 48-bit generator state, and compares responses in order.
// ----------------------------------------------------------------------------
module jrlcg_draw_checker
  import jrlcg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_stall,
  input  wire req_t req_data,
  input  wire logic rsp_valid,
  input  wire logic rsp_stall,
  input  wire rsp_t rsp_data,
  output int        mismatch_count,
  output int        draws_pending
);

  localparam bit [47:0] STEP_MUL    = 48'h5DEECE66D;
  localparam bit [47:0] STEP_INC    = 48'hB;
  localparam int        REPORT_CAP  = 10;
  localparam longint unsigned INT_MAX31 = 64'h7FFF_FFFF;

  bit [47:0] gen_state;
  rsp_t      draw_q[$];
  int        errs;

  // Advance the generator one step and return its top nbits
  function automatic bit [31:0] step_bits(int unsigned nbits);
    gen_state = gen_state * STEP_MUL + STEP_INC;
    return 32'(gen_state >> (48 - nbits));
  endfunction

  // Work out the response of one request and update the local state
  function automatic rsp_t predict_draw(req_t r);
    rsp_t            p;
    bit [63:0]       val;
    bit [31:0]       hi;
    bit [31:0]       lo;
    longint unsigned bits;
    longint unsigned rem;
    longint unsigned bnd;
    int unsigned     nb;
    val = '0;
    case (r.op)
      OP_SET_SEED: begin
        gen_state = r.seed_value ^ STEP_MUL;
      end
      OP_NEXT: begin
        if (r.bit_count == 0) begin
          void'(step_bits(1));
        end else begin
          nb  = (r.bit_count > 32) ? 32 : r.bit_count;
          lo  = step_bits(nb);
          val = {{32{lo[31]}}, lo};
        end
      end
      OP_INT: begin
        if (r.bound != 0) begin
          bnd  = r.bound;
          bits = step_bits(31);
          rem  = bits % bnd;
          // redraw while the reduction would bias the result
          while (bits - rem + (bnd - 1) > INT_MAX31) begin
            bits = step_bits(31);
            rem  = bits % bnd;
          end
          val = rem;
        end
      end
      OP_LONG: begin
        hi  = step_bits(32);
        lo  = step_bits(32);
        val = {hi, 32'h0} + {{32{lo[31]}}, lo};
      end
      OP_DOUBLE: begin
        hi  = step_bits(26);
        lo  = step_bits(27);
        val = (64'(hi) << 27) + 64'(lo);
      end
      default: begin
      end
    endcase
    p.result_value = val;
    p.state_after  = gen_state;
    return p;
  endfunction

  // Check responses against the oldest prediction, then queue new requests
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      gen_state = '0;
      draw_q.delete();
      errs = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (draw_q.size() == 0) begin
          if (errs < REPORT_CAP)
            $display("%0t: response with no request waiting: value %0d state %h",
                     $realtime, rsp_data.result_value, rsp_data.state_after);
          errs++;
        end else begin
          want = draw_q.pop_front();
          if (rsp_data.result_value !== want.result_value ||
              rsp_data.state_after !== want.state_after) begin
            if (errs < REPORT_CAP)
              $display("%0t: draw mismatch: want value %0d state %h, got value %0d state %h",
                       $realtime, want.result_value, want.state_after,
                       rsp_data.result_value, rsp_data.state_after);
            errs++;
          end
        end
      end
      if (req_valid && !req_stall)
        draw_q.push_back(predict_draw(req_data));
    end
    mismatch_count <= errs;
    draws_pending  <= draw_q.size();
  end

endmodule

// ===== tb/java_random_lcg_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// java_random_lcg_generator_unit_tb
// Drives seed loads and draws of every kind into the LCG unit with random
// gaps and stalls on both channels; a checker beside the unit predicts and
// compares every response.
// ----------------------------------------------------------------------------
module java_random_lcg_generator_unit_tb;
  import jrlcg_pkg::*;

  localparam int         RESET_CYCLES  = 9;
  localparam int         RANDOM_ITEMS  = 2000;
  localparam int         PHASE1_START  = 700;
  localparam int         PHASE2_START  = 1400;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         DRAIN_CYCLES  = 80;
  localparam int         QUIET_LIMIT   = 6000;
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_MID   = 3'd6;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  int   phase     = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   mismatch_count;
  int   draws_pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  java_random_lcg_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  jrlcg_draw_checker draw_check (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_data       (req_data),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp_data       (rsp_data),
    .mismatch_count (mismatch_count),
    .draws_pending  (draws_pending)
  );

  function automatic int sender_idle_pct(int ph);
    case (ph)
      0:       return 11;
      1:       return 59;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(int ph);
    case (ph)
      0:       return 59;
      1:       return 11;
      default: return 0;
    endcase
  endfunction

  function automatic req_t build_request(logic [2:0] op, logic [47:0] seed,
                                         logic [5:0] nb, logic [30:0] bnd);
    req_t r;
    r.op         = op;
    r.seed_value = seed;
    r.bit_count  = nb;
    r.bound      = bnd;
    return r;
  endfunction

  // Mostly well-formed draws; bounds lean small, with a few huge or biased ones
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.seed_value = 48'({$urandom, $urandom});
    r.bit_count  = ($urandom_range(99) < 80) ? 6'($urandom_range(1, 32))
                                             : 6'($urandom_range(0, 63));
    case ($urandom_range(9))
      0, 1, 2: r.bound = 31'($urandom_range(1, 20));
      3, 4:    r.bound = 31'($urandom_range(1, 65535));
      5, 6:    r.bound = 31'($urandom);
      7:       r.bound = 31'(1) << $urandom_range(30);
      8:       r.bound = 31'h4000_0000 + 31'($urandom_range(0, 255));
      default: r.bound = ($urandom_range(1)) ? 31'h0
                                             : 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
    endcase
    pick = $urandom_range(99);
    if (pick < 10)      r.op = OP_SET_SEED;
    else if (pick < 35) r.op = OP_NEXT;
    else if (pick < 65) r.op = OP_INT;
    else if (pick < 80) r.op = OP_LONG;
    else if (pick < 96) r.op = OP_DOUBLE;
    else                r.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    return r;
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic offer_request(req_t r);
    while ($urandom_range(99) < sender_idle_pct(phase)) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off when the last phase opens
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase == 2 && !hold_done) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct(phase));
    end
  end

  // End the run if nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // draw from the reset state, then bit count edges
    offer_request(build_request(OP_NEXT, '0, 6'd32, '0));
    offer_request(build_request(OP_SET_SEED, 48'h0, '0, '0));
    offer_request(build_request(OP_NEXT, '0, 6'd0, '0));
    offer_request(build_request(OP_NEXT, '0, 6'd1, '0));
    offer_request(build_request(OP_NEXT, '0, 6'd31, '0));
    offer_request(build_request(OP_NEXT, '0, 6'd32, '0));
    offer_request(build_request(OP_NEXT, '0, 6'd33, '0));
    offer_request(build_request(OP_NEXT, '1, 6'd63, '1));
    // bounded draws: zero, tiny, power of two, max, and a high-rejection bound
    offer_request(build_request(OP_SET_SEED, '1, '0, '0));
    offer_request(build_request(OP_INT, '0, '0, 31'd0));
    offer_request(build_request(OP_INT, '0, '0, 31'd1));
    offer_request(build_request(OP_INT, '0, '0, 31'd2));
    offer_request(build_request(OP_INT, '0, '0, 31'd16));
    offer_request(build_request(OP_INT, '0, '0, 31'h7FFF_FFFF));
    offer_request(build_request(OP_INT, '0, '0, 31'h4000_0001));
    offer_request(build_request(OP_LONG, '0, '0, '0));
    offer_request(build_request(OP_DOUBLE, '0, '0, '0));
    // unused codes leave the state alone
    offer_request(build_request(OP_RSVD_FIRST, '1, '1, '1));
    offer_request(build_request(OP_RSVD_MID, '0, '0, '0));
    offer_request(build_request(OP_RSVD_LAST, '1, '1, '1));
    // seed that scrambles to an all-zero state
    offer_request(build_request(OP_SET_SEED, 48'h5_DEEC_E66D, '0, '0));
    offer_request(build_request(OP_LONG, '0, '0, '0));
    offer_request(build_request(OP_DOUBLE, '0, '0, '0));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PHASE1_START)
        phase <= 1;
      else if (n == PHASE2_START)
        phase <= 2;
      offer_request(random_request());
    end
    req_valid <= 1'b0;

    // drain outstanding draws, then let the unit settle
    @(posedge clk);
    while (draws_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
